// File: rtl/core/olist_pkg.sv
// Shared types, codes and constants for the ordered list engine.
package olist_pkg;

  localparam int CAP_DEFAULT = 16;

  typedef enum logic [2:0] {
    OP_INS_FRONT  = 3'd0,
    OP_INS_BACK   = 3'd1,
    OP_REM_FRONT  = 3'd2,
    OP_REM_BACK   = 3'd3,
    OP_INS_SORTED = 3'd4,
    OP_REM_VALUE  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } olist_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic signed [31:0] head_value;
  } olist_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_FINISH
  } olist_state_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_COUNT_M1,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_ZERO,
    POS_COUNT,
    POS_IDX
  } pos_op_e;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1
  } rd_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef struct packed {
    logic    capture;
    idx_op_e idx_op;
    pos_op_e pos_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_final;   // write new value at pos, else shifted data at idx
    cnt_op_e cnt_op;
    logic    set_status;
    status_e status;
    logic    load_out;
  } olist_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_gt_pos;
    logic more_after;   // idx + 1 < count
    logic at_end;       // idx == count
    logic less;         // read entry < request value
    logic equal;        // read entry == request value
  } olist_stat_t;

endpackage

// File: rtl/core/olist_dp.sv
// Datapath: entry memory, index and position counters, head shadow, result register.
module olist_dp import olist_pkg::*; #(
  parameter int CAPACITY = CAP_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  olist_in_t   in_data,
  input  olist_cmd_t  cmd,
  output olist_stat_t stat,
  output olist_out_t  out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] val_q;
  logic signed [31:0] rdata;
  logic signed [31:0] head;
  logic signed [31:0] wr_data;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      pos;
  logic [CW-1:0]      rd_ptr;
  logic [CW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  status_e            st_q;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_IDX_M1: rd_ptr = idx - CW'(1);
      RD_IDX_P1: rd_ptr = idx + CW'(1);
      default:   rd_ptr = idx;
    endcase
  end

  assign wr_ptr  = cmd.wr_final ? pos : idx;
  assign wr_data = cmd.wr_final ? val_q : rdata;
  // pointers are below CAPACITY whenever a read or write is issued
  assign rd_addr = rd_ptr[AW-1:0];
  assign wr_addr = wr_ptr[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // shadow of entry zero, so the result never needs a memory read
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ptr == '0) begin
      head <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val_q <= in_data.value;
    end
    if (cmd.set_status) begin
      st_q <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.idx_op)
      IDX_ZERO:     idx <= '0;
      IDX_COUNT:    idx <= count;
      IDX_COUNT_M1: idx <= count - CW'(1);
      IDX_INC:      idx <= idx + CW'(1);
      IDX_DEC:      idx <= idx - CW'(1);
      default:      idx <= idx;
    endcase
    unique case (cmd.pos_op)
      POS_ZERO:  pos <= '0;
      POS_COUNT: pos <= count;
      POS_IDX:   pos <= idx;
      default:   pos <= pos;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.status      <= st_q;
      out_data.entry_count <= 5'(count);
      out_data.is_empty    <= (count == '0);
      out_data.head_value  <= (count == '0) ? 32'sd0 : head;
    end
  end

  always_comb begin
    stat.full       = (count == CW'(CAPACITY));
    stat.empty      = (count == '0);
    stat.idx_gt_pos = (idx > pos);
    stat.more_after = ((idx + CW'(1)) < count);
    stat.at_end     = (idx == count);
    stat.less       = (rdata < val_q);
    stat.equal      = (rdata == val_q);
  end

endmodule

// File: rtl/core/olist_ctrl.sv
// Controller: sequences search, shift and result steps for one item at a time.
module olist_ctrl import olist_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [2:0]  in_op,
  input  logic        out_ready,
  input  olist_stat_t stat,
  output logic        in_ready,
  output logic        out_valid,
  output olist_cmd_t  cmd
);

  olist_state_e state;
  olist_state_e state_next;
  logic         rem_mode;
  logic         out_free;
  logic         accept;

  assign out_free = !out_valid || out_ready;
  assign accept   = (state == S_IDLE) && in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rem_mode  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        rem_mode <= (in_op == OP_REM_VALUE);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_INS_FRONT, OP_INS_BACK:
              state_next = stat.full ? S_FINISH : S_INS_RD;
            OP_INS_SORTED:
              state_next = stat.full ? S_FINISH : S_SRCH_RD;
            OP_REM_FRONT, OP_REM_BACK:
              state_next = stat.empty ? S_FINISH : S_REM_RD;
            OP_REM_VALUE:
              state_next = stat.empty ? S_FINISH : S_SRCH_RD;
            default:
              state_next = S_FINISH;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (!stat.at_end) begin
          state_next = S_SRCH_CHK;
        end else begin
          state_next = rem_mode ? S_FINISH : S_INS_RD;
        end
      end
      S_SRCH_CHK: begin
        priority if (stat.less) begin
          state_next = S_SRCH_RD;
        end else if (!rem_mode) begin
          state_next = S_INS_RD;
        end else if (stat.equal) begin
          state_next = S_REM_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_INS_RD: state_next = stat.idx_gt_pos ? S_INS_WR : S_FINISH;
      S_INS_WR: state_next = S_INS_RD;
      S_REM_RD: state_next = stat.more_after ? S_REM_WR : S_FINISH;
      S_REM_WR: state_next = S_REM_RD;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready       = (state == S_IDLE);
    cmd.capture    = 1'b0;
    cmd.idx_op     = IDX_HOLD;
    cmd.pos_op     = POS_HOLD;
    cmd.rd_en      = 1'b0;
    cmd.rd_sel     = RD_IDX;
    cmd.wr_en      = 1'b0;
    cmd.wr_final   = 1'b0;
    cmd.cnt_op     = CNT_HOLD;
    cmd.set_status = 1'b0;
    cmd.status     = ST_DONE;
    cmd.load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture    = 1'b1;
          cmd.set_status = 1'b1;
          unique case (in_op)
            OP_INS_FRONT: begin
              cmd.status = stat.full ? ST_FULL : ST_DONE;
              cmd.idx_op = IDX_COUNT;
              cmd.pos_op = POS_ZERO;
            end
            OP_INS_BACK: begin
              cmd.status = stat.full ? ST_FULL : ST_DONE;
              cmd.idx_op = IDX_COUNT;
              cmd.pos_op = POS_COUNT;
            end
            OP_INS_SORTED: begin
              cmd.status = stat.full ? ST_FULL : ST_DONE;
              cmd.idx_op = IDX_ZERO;
            end
            OP_REM_FRONT: begin
              cmd.status = stat.empty ? ST_EMPTY : ST_DONE;
              cmd.idx_op = IDX_ZERO;
            end
            OP_REM_BACK: begin
              cmd.status = stat.empty ? ST_EMPTY : ST_DONE;
              cmd.idx_op = IDX_COUNT_M1;
            end
            OP_REM_VALUE: begin
              cmd.status = stat.empty ? ST_EMPTY : ST_DONE;
              cmd.idx_op = IDX_ZERO;
            end
            default: cmd.status = ST_DONE;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (!stat.at_end) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
        end else if (rem_mode) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOTFOUND;
        end else begin
          cmd.pos_op = POS_IDX;   // idx already equals count
        end
      end
      S_SRCH_CHK: begin
        priority if (stat.less) begin
          cmd.idx_op = IDX_INC;
        end else if (!rem_mode) begin
          cmd.pos_op = POS_IDX;
          cmd.idx_op = IDX_COUNT;
        end else if (!stat.equal) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOTFOUND;
        end
      end
      S_INS_RD: begin
        if (stat.idx_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.wr_final = 1'b1;
          cmd.cnt_op   = CNT_INC;
        end
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_DEC;
      end
      S_REM_RD: begin
        if (stat.more_after) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P1;
        end else begin
          cmd.cnt_op = CNT_DEC;
        end
      end
      S_REM_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.idx_op = IDX_INC;
      end
      S_FINISH: cmd.load_out = out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/ordered_list_engine_unit.sv
// Top level of the ordered list engine: controller plus datapath.
//
//   channel | signals                        | payload
//   --------+--------------------------------+----------------------------------
//   request | in_valid, in_ready, in_data    | operation, value
//   result  | out_valid, out_ready, out_data | status, entry_count, is_empty,
//           |                                |   head_value
//
// One item at a time. Rejected items and unused codes go straight to the result
// state; otherwise each entry searched takes a read and a check state, and each
// entry shifted a read and a write state, as the controller issues a registered
// read or a write to the entry memory, never both at once. Reset clears the count
// and control; memory content is not cleared and is never read beyond the count.
// A stalled result holds in the output register while the next item is accepted and processed.
module ordered_list_engine_unit import olist_pkg::*; #(
  parameter int CAPACITY = CAP_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  olist_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output olist_out_t out_data
);

  olist_cmd_t  cmd;
  olist_stat_t stat;

  olist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  olist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// File: rtl/core/olist_chk.sv
// Port-level checker for the ordered list engine, bound to the top level.
module olist_chk import olist_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input olist_in_t  in_data,
  input logic       out_valid,
  input logic       out_ready,
  input olist_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_empty |-> out_data.entry_count == 5'd0 &&
      out_data.head_value == 32'sd0)
    else $error("empty result with nonzero count or head");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_EMPTY |-> out_data.is_empty)
    else $error("empty status on a non-empty list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FULL |-> !out_data.is_empty)
    else $error("full status on an empty list");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule

bind ordered_list_engine_unit olist_chk u_olist_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: dv/ordered_list_engine_unit_tb.sv
// Self-checking testbench for the ordered list engine: mirrored list, directed and random traffic.
module ordered_list_engine_unit_tb import olist_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = CAP_DEFAULT;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 800_000;
  localparam int HOLDOFF_AT   = 150;
  localparam int HOLDOFF_LEN  = 400;

  // codes the block does not define; they must leave the list alone
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  class list_mirror;
    logic signed [31:0] entries [DEPTH];
    int                 fill;
    olist_out_t         pending [$];
    int                 errors;
    int                 checked;

    function new();
      fill    = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function int first_not_less(logic signed [31:0] v);
      int i;
      i = 0;
      while (i < fill && entries[i] < v) i++;
      return i;
    endfunction

    function void note_request(olist_in_t req);
      olist_out_t         res;
      status_e            st;
      logic signed [31:0] v;
      int                 pos;
      int                 i;
      st  = ST_DONE;
      v   = $signed(req.value);
      pos = 0;
      case (req.operation)
        OP_INS_FRONT, OP_INS_BACK, OP_INS_SORTED: begin
          if (fill >= DEPTH) begin
            st = ST_FULL;
          end else begin
            if (req.operation == OP_INS_BACK) pos = fill;
            else if (req.operation == OP_INS_SORTED) pos = first_not_less(v);
            for (i = fill; i > pos; i--) entries[i] = entries[i - 1];
            entries[pos] = v;
            fill++;
          end
        end
        OP_REM_FRONT, OP_REM_BACK, OP_REM_VALUE: begin
          if (fill == 0) begin
            st = ST_EMPTY;
          end else begin
            if (req.operation == OP_REM_BACK) begin
              pos = fill - 1;
            end else if (req.operation == OP_REM_VALUE) begin
              pos = first_not_less(v);
              if (pos >= fill || entries[pos] != v) st = ST_NOTFOUND;
            end
            if (st == ST_DONE) begin
              for (i = pos; i + 1 < fill; i++) entries[i] = entries[i + 1];
              fill--;
            end
          end
        end
        default: ;
      endcase
      res.status      = st;
      res.entry_count = 5'(fill);
      res.is_empty    = (fill == 0);
      res.head_value  = (fill == 0) ? '0 : entries[0];
      pending.push_back(res);
    endfunction

    function void check_result(olist_out_t got);
      olist_out_t exp;
      checked++;
      if (pending.size() == 0) begin
        $error("result with no item pending: status %0d count %0d", got.status,
               got.entry_count);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.entry_count !== exp.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
        errors++;
      end
      if (got.is_empty !== exp.is_empty) begin
        $error("is_empty: expected %0d, got %0d", exp.is_empty, got.is_empty);
        errors++;
      end
      if (got.head_value !== exp.head_value) begin
        $error("head_value: expected %0d, got %0d", $signed(exp.head_value),
               $signed(got.head_value));
        errors++;
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  olist_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  olist_out_t out_data;

  list_mirror sb = new();
  int         cycle_count = 0;

  ordered_list_engine_unit #(.CAPACITY(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // sample pre-edge values; inputs change only by NBA at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_request(in_data);
    end
  end

  // call at a rising edge; returns at the edge the item is taken, valid still high
  task automatic send_request(input logic [2:0] op, input logic signed [31:0] v);
    in_valid <= 1'b1;
    in_data  <= '{operation: op, value: v};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 16) - 8;
      4: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // bias 0 grows the list, 1 drains it, 2 keeps it balanced
  function automatic void pick_request(input int bias, output logic [2:0] op,
                                       output logic signed [31:0] v);
    int r;
    int ins_pct;
    r       = $urandom_range(0, 99);
    ins_pct = (bias == 0) ? 72 : (bias == 1) ? 25 : 50;
    v       = pick_value();
    if (r < 3) begin
      op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
    end else if (r < ins_pct) begin
      case ($urandom_range(0, 3))
        0: op = OP_INS_FRONT;
        1: op = OP_INS_BACK;
        default: op = OP_INS_SORTED;
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: op = OP_REM_FRONT;
        1: op = OP_REM_BACK;
        default: begin
          op = OP_REM_VALUE;
          // mostly aim at a held entry so removals actually hit
          if (sb.fill > 0 && $urandom_range(0, 9) < 7)
            v = sb.entries[$urandom_range(0, sb.fill - 1)];
        end
      endcase
    end
  endfunction

  // result side: segments of different stall patterns plus one long hold-off
  initial begin : result_sink
    int seg_len;
    int mode;
    int period;
    int k;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && sb.checked >= HOLDOFF_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLDOFF_LEN) @(posedge clk);
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(1, 40);
      period  = $urandom_range(2, 6);
      for (k = 0; k < seg_len; k++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ((k % period) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : request_source
    int                 n;
    int                 b;
    int                 k;
    int                 burst;
    int                 gap;
    int                 bias;
    logic [2:0]         op;
    logic signed [31:0] v;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty list: every removal flagged, spare codes report the idle state
    send_request(OP_REM_FRONT, VAL_MAX);
    send_request(OP_REM_BACK, VAL_MIN);
    send_request(OP_REM_VALUE, '0);
    send_request(OP_SPARE_A, -1);
    send_request(OP_SPARE_B, VAL_MAX);

    // extremes at both ends, sorted placement, value miss and hit
    send_request(OP_INS_FRONT, VAL_MAX);
    send_request(OP_INS_BACK, VAL_MIN);
    send_request(OP_INS_SORTED, '0);
    send_request(OP_REM_VALUE, 32'sd5);
    send_request(OP_REM_VALUE, '0);

    // fill up, then every insert bounces off a full list
    for (k = 0; k < DEPTH - 2; k++) send_request(OP_INS_SORTED, pick_value());
    send_request(OP_INS_FRONT, -1);
    send_request(OP_INS_BACK, '0);
    send_request(OP_INS_SORTED, VAL_MIN);
    send_request(OP_SPARE_B, '0);

    bias = 1;
    for (n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 24);
      for (b = 0; b < burst && n < RANDOM_ITEMS; b++) begin
        if (n % 48 == 0) bias = $urandom_range(0, 2);
        pick_request(bias, op, v);
        send_request(op, v);
        n++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/olist_pkg.sv
rtl/core/olist_dp.sv
rtl/core/olist_ctrl.sv
rtl/core/ordered_list_engine_unit.sv
rtl/core/olist_chk.sv
dv/ordered_list_engine_unit_tb.sv
